### rtl/e2q_pkg.sv
// Shared types, constants and helpers for the Euler-to-quaternion unit.
// No dependencies.
package e2q_pkg;

  localparam int CORDIC_STAGES = 16;

  localparam logic [1:0] ORDER_XYZ  = 2'd0;
  localparam logic [1:0] ORDER_ZXY  = 2'd1;
  localparam logic [1:0] ORDER_YZX  = 2'd2;
  localparam logic [1:0] ORDER_NONE = 2'd3;

  localparam logic CFG_AXIS_ORDER = 1'b0;
  localparam logic CFG_DEGREES    = 1'b1;

  localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [31:0] RAD_PHASE_K = 32'sd341782638;

  typedef struct packed {
    logic signed [31:0] roll_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } quat_t;

  // Rotator state for one angle: x, y near 2^30 are held in 34 bits for headroom.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         quad;
  } rot_t;

  // Arc tangent table, 2^32 per turn.
  function automatic logic signed [33:0] atan_turns(input int i);
    logic signed [33:0] t;
    case (i)
      0: t = 34'sd536870912;  1: t = 34'sd316933406;  2: t = 34'sd167458907;
      3: t = 34'sd85004756;   4: t = 34'sd42667331;   5: t = 34'sd21354465;
      6: t = 34'sd10679838;   7: t = 34'sd5340245;    8: t = 34'sd2670163;
      9: t = 34'sd1335087;    10: t = 34'sd667544;    11: t = 34'sd333772;
      12: t = 34'sd166886;    13: t = 34'sd83443;     14: t = 34'sd41722;
      15: t = 34'sd20861;     16: t = 34'sd10430;     17: t = 34'sd5215;
      18: t = 34'sd2608;      19: t = 34'sd1304;      20: t = 34'sd652;
      21: t = 34'sd326;       22: t = 34'sd163;       23: t = 34'sd81;
      24: t = 34'sd41;        25: t = 34'sd20;        26: t = 34'sd10;
      27: t = 34'sd5;         28: t = 34'sd3;         29: t = 34'sd1;
      default: t = 34'sd0;
    endcase
    return t;
  endfunction

  // Q30 product rounded half up: floor((a*b + 2^29) / 2^30).
  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return p[63:30];
  endfunction

endpackage

### rtl/e2q_phase.sv
// Angle to half-angle phase conversion, one register stage.
// Depends on e2q_pkg.
module e2q_phase (
  input  logic               clk,
  input  logic               deg,
  input  logic signed [31:0] angle,
  output logic [31:0]        phase
);
  // Degrees: floor((2^13 a + 45) / 90) equals 91 a + floor((a + 22) / 45),
  // since 4095 = 91 * 45. The quotient by 45 is taken on a + 22 + 45 * 2^26,
  // which is always positive and below 2^33, by a reciprocal multiplication
  // that is exact over that range; the offset quotient 2^26 is then removed.
  localparam logic [33:0] DEG_OFFSET  = 34'd3019898902;
  localparam logic [33:0] RECIP_45    = 34'd12216795865;
  localparam logic [31:0] DEG_SCALE   = 32'd91;
  localparam logic [31:0] OFFSET_QUOT = 32'h0400_0000;

  logic signed [63:0] prod_rad;
  logic [31:0]        q_rad;
  logic [32:0]        s_off;
  logic [66:0]        recip;
  logic [31:0]        q_deg;

  always_comb begin
    prod_rad = 64'(angle) * 64'(e2q_pkg::RAD_PHASE_K) + 64'sd32768;
    q_rad    = prod_rad[47:16];
    s_off    = 33'(34'(angle) + DEG_OFFSET);
    recip    = 67'(s_off) * 67'(RECIP_45);
    q_deg    = 32'(angle) * DEG_SCALE + 32'(recip[66:39]) - OFFSET_QUOT;
  end

  always_ff @(posedge clk) begin
    phase <= deg ? q_deg : q_rad;
  end
endmodule

### rtl/e2q_cordic_cell.sv
// One CORDIC rotation cell with its output register.
// Depends on e2q_pkg.
module e2q_cordic_cell (
  input  logic            clk,
  input  logic [4:0]      stage,
  input  e2q_pkg::rot_t   din,
  output e2q_pkg::rot_t   dout
);
  e2q_pkg::rot_t nxt;
  logic signed [33:0] dx;
  logic signed [33:0] dy;

  always_comb begin
    dx = din.x >>> stage;
    dy = din.y >>> stage;
    nxt = din;
    if (din.z >= 0) begin
      nxt.x = din.x - dy;
      nxt.y = din.y + dx;
      nxt.z = din.z - e2q_pkg::atan_turns(int'(stage));
    end else begin
      nxt.x = din.x + dy;
      nxt.y = din.y - dx;
      nxt.z = din.z + e2q_pkg::atan_turns(int'(stage));
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end
endmodule

### rtl/e2q_sincos.sv
// Half-angle cosine and sine through a chain of CORDIC cells.
// Depends on e2q_pkg, e2q_phase and e2q_cordic_cell.
module e2q_sincos (
  input  logic               clk,
  input  logic               deg,
  input  logic signed [31:0] angle,
  output logic signed [33:0] cosv,
  output logic signed [33:0] sinv
);
  logic [31:0] phase;
  logic [31:0] shifted;
  logic [31:0] resid;
  e2q_pkg::rot_t chain [0:e2q_pkg::CORDIC_STAGES];

  e2q_phase u_phase (.clk(clk), .deg(deg), .angle(angle), .phase(phase));

  always_comb begin
    shifted = phase + 32'h2000_0000;
    resid   = phase - {shifted[31:30], 30'd0};
  end

  assign chain[0] = '{x: 34'(e2q_pkg::GAIN_Q30), y: 34'sd0,
                      z: 34'($signed(resid)), quad: shifted[31:30]};

  for (genvar g = 0; g < e2q_pkg::CORDIC_STAGES; g++) begin : g_cell
    e2q_cordic_cell u_cell (
      .clk(clk), .stage(5'(g)), .din(chain[g]), .dout(chain[g+1])
    );
  end

  always_comb begin
    case (chain[e2q_pkg::CORDIC_STAGES].quad)
      2'd0: begin
        cosv = chain[e2q_pkg::CORDIC_STAGES].x;
        sinv = chain[e2q_pkg::CORDIC_STAGES].y;
      end
      2'd1: begin
        cosv = -chain[e2q_pkg::CORDIC_STAGES].y;
        sinv = chain[e2q_pkg::CORDIC_STAGES].x;
      end
      2'd2: begin
        cosv = -chain[e2q_pkg::CORDIC_STAGES].x;
        sinv = -chain[e2q_pkg::CORDIC_STAGES].y;
      end
      default: begin
        cosv = chain[e2q_pkg::CORDIC_STAGES].y;
        sinv = -chain[e2q_pkg::CORDIC_STAGES].x;
      end
    endcase
  end
endmodule

### rtl/euler_to_quaternion_unit.sv
// Top level of the Euler-to-quaternion unit.
// Depends on e2q_pkg and e2q_sincos.
//
// Usage: an angle triple is transferred at a rising edge where start is high
// and busy is low. busy is always low, so a new triple may be transferred in
// every cycle. Each result appears on result for exactly one cycle with done
// high; the receiver cannot stall the unit and must take it then.
// The pipeline registers, in order, the phase conversion, the output of each
// CORDIC cell, the pairwise products, the triple products and the signed sums
// and saturation. Throughput is one triple per cycle, set by the fully
// pipelined cell chain. The axis order and angle units are sampled at the
// input, so they apply to triples transferred after the write.
// Synchronous reset clears the configuration to XYZ and radians and drops all
// results in flight.
module euler_to_quaternion_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  e2q_pkg::angles_t  angles,
  output logic              done,
  output e2q_pkg::quat_t    result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_data
);
  localparam int LAT = e2q_pkg::CORDIC_STAGES + 1;

  logic [1:0] axis_order;
  logic       degrees;
  logic [LAT+2:0] vld;
  logic [1:0] ord_pipe [0:LAT+1];
  logic signed [33:0] c1, s1, c2, s2, c3, s3;
  logic signed [33:0] cc, ss, sc, cs;
  logic signed [33:0] c3r, s3r;
  logic signed [33:0] ccc, sss, scc, css, csc, scs, ccs, ssc;
  logic signed [35:0] w, x, y, z;
  e2q_pkg::quat_t q_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_order <= e2q_pkg::ORDER_XYZ;
      degrees    <= 1'b0;
      vld        <= '0;
    end else begin
      if (cfg_we && cfg_index == e2q_pkg::CFG_AXIS_ORDER) begin
        axis_order <= cfg_data;
      end
      if (cfg_we && cfg_index == e2q_pkg::CFG_DEGREES) begin
        degrees <= cfg_data[0];
      end
      vld <= {vld[LAT+1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    ord_pipe[0] <= axis_order;
    for (int i = 1; i <= LAT + 1; i++) begin
      ord_pipe[i] <= ord_pipe[i-1];
    end
  end

  e2q_sincos u_roll (.clk(clk), .deg(degrees), .angle(angles.roll_angle),
                     .cosv(c1), .sinv(s1));
  e2q_sincos u_pitch (.clk(clk), .deg(degrees), .angle(angles.pitch_angle),
                      .cosv(c2), .sinv(s2));
  e2q_sincos u_yaw (.clk(clk), .deg(degrees), .angle(angles.yaw_angle),
                    .cosv(c3), .sinv(s3));

  // Pairwise products of the first two axes, then the triple products.
  always_ff @(posedge clk) begin
    cc  <= e2q_pkg::mul_q30(c1, c2);
    ss  <= e2q_pkg::mul_q30(s1, s2);
    sc  <= e2q_pkg::mul_q30(s1, c2);
    cs  <= e2q_pkg::mul_q30(c1, s2);
    c3r <= c3;
    s3r <= s3;
    ccc <= e2q_pkg::mul_q30(cc, c3r);
    sss <= e2q_pkg::mul_q30(ss, s3r);
    scc <= e2q_pkg::mul_q30(sc, c3r);
    css <= e2q_pkg::mul_q30(cs, s3r);
    csc <= e2q_pkg::mul_q30(cs, c3r);
    scs <= e2q_pkg::mul_q30(sc, s3r);
    ccs <= e2q_pkg::mul_q30(cc, s3r);
    ssc <= e2q_pkg::mul_q30(ss, c3r);
  end

  function automatic logic signed [31:0] sat(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    w = 36'(ccc) - 36'(sss);
    case (ord_pipe[LAT+1])
      e2q_pkg::ORDER_XYZ: begin
        x = 36'(scc) + 36'(css); y = 36'(csc) - 36'(scs); z = 36'(ccs) + 36'(ssc);
      end
      e2q_pkg::ORDER_ZXY: begin
        x = 36'(scc) - 36'(css); y = 36'(csc) + 36'(scs); z = 36'(ccs) + 36'(ssc);
      end
      default: begin
        x = 36'(scc) + 36'(css); y = 36'(csc) + 36'(scs); z = 36'(ccs) - 36'(ssc);
      end
    endcase
    if (ord_pipe[LAT+1] == e2q_pkg::ORDER_NONE) begin
      q_next.quat_w = e2q_pkg::ONE_Q30;
      q_next.quat_x = '0;
      q_next.quat_y = '0;
      q_next.quat_z = '0;
    end else begin
      q_next.quat_w = sat(w);
      q_next.quat_x = sat(x);
      q_next.quat_y = sat(y);
      q_next.quat_z = sat(z);
    end
  end

  always_ff @(posedge clk) begin
    result <= q_next;
  end

  assign done = vld[LAT+2];
endmodule
